[rtl/ptm_pkg.sv]
// Package with opcodes, status codes and result types of the playback timeline block.
package ptm_pkg;
  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_PLAY = 3'd1;
  localparam logic [2:0] OP_PAUSE = 3'd2;
  localparam logic [2:0] OP_TOGGLE = 3'd3;
  localparam logic [2:0] OP_SEEK_TIME = 3'd4;
  localparam logic [2:0] OP_SEEK_PIXEL = 3'd5;
  localparam logic [2:0] OP_ADD_MARKER = 3'd6;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_ADDED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_PAST_END = 2'd3;

  localparam logic [1:0] REG_LENGTH = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_SPEED = 2'd2;

  localparam int unsigned SpeedMax = 4096;

  typedef struct packed {
    logic [4:0] added_slot;
    logic [1:0] add_status;
    logic [4:0] prev_index;
    logic       prev_found;
    logic [4:0] next_index;
    logic       next_found;
    logic [15:0] playhead_pixel;
    logic       reached_end;
    logic       is_playing;
    logic [31:0] playhead_now;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [31:0] divisor;
  } div_req_t;
endpackage

[rtl/ptm_ram.sv]
// Generic single-port-write, single-read synchronous RAM with registered read.
module ptm_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/ptm_div.sv]
// Restoring divider, one quotient bit per cycle, 48-bit dividend by 32-bit divisor.
module ptm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptm_pkg::div_req_t req_i,
  output logic              busy_o,
  output logic [47:0]       quot_o
);
  logic [47:0] quot_q, quot_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] trial;
  logic [32:0] diff;

  always_comb begin
    quot_d = quot_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = '0;
    diff = '0;
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
      cnt_d = 6'd48;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quot_q[47]};
      diff = trial - {1'b0, dvs_q};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[31:0];
        quot_d = {quot_q[46:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        quot_d = {quot_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
endmodule

[rtl/playback_timeline_with_markers.sv]
// Top level of the playback timeline block with its sorted marker table.
// Timing: an item may wait before its result until the previous result is taken;
// each pixel division runs one quotient bit per cycle over 48 quotient bits,
// and inserting or searching reads and then compares each marker visited.
// Throughput: one item at a time; the next item is taken once the block is idle again,
// while the previous result may still wait in the output register.
// Reset: playhead 0, paused, marker table empty, length 0, width 1, speed 256.
module playback_timeline_with_markers #(
  parameter int MarkerSlots = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[2:0], time_value[34:3], pixel_position[50:35], zero fill
  input  logic [55:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // playhead_now, is_playing, reached_end, playhead_pixel, next_found, next_index,
  // prev_found, prev_index, add_status, added_slot, zero fill
  output logic [71:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_wdata_i
);
  localparam int AW = (MarkerSlots > 1) ? $clog2(MarkerSlots) : 1;
  localparam int CW = $clog2(MarkerSlots + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SPX = 4'd1;
  localparam logic [3:0] S_SPXW = 4'd2;
  localparam logic [3:0] S_INS_RD = 4'd3;
  localparam logic [3:0] S_INS_CMP = 4'd4;
  localparam logic [3:0] S_SRCH_RD = 4'd5;
  localparam logic [3:0] S_SRCH_CMP = 4'd6;
  localparam logic [3:0] S_PIX = 4'd7;
  localparam logic [3:0] S_PIXW = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;
  localparam logic [3:0] S_TICK = 4'd10;

  logic [3:0] state_q, state_d;
  logic [31:0] len_q, len_d;
  logic [15:0] width_q, width_d;
  logic [12:0] speed_q, speed_d;
  logic [31:0] ph_q, ph_d;
  logic run_q, run_d;
  logic [CW-1:0] total_q, total_d;
  logic [31:0] tv_q, tv_d;
  logic [15:0] px_q, px_d;
  logic [CW-1:0] pos_q, pos_d;
  logic nf_q, nf_d, pf_q, pf_d, reached_q, reached_d;
  logic [AW-1:0] ni_q, ni_d, pi_q, pi_d;
  logic [1:0] status_q, status_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [44:0] prod_q, prod_d;
  logic ovalid_q, ovalid_d;
  ptm_pkg::result_t res_q, res_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;
  ptm_pkg::div_req_t dreq;
  logic dbusy;
  logic [47:0] dquot;
  logic [32:0] step_w, sum_w;
  logic [15:0] xcl;
  logic in_acc;

  ptm_ram #(.Width(32), .Depth(MarkerSlots)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );
  ptm_div u_div (.clk_i, .rst_ni, .req_i(dreq), .busy_o(dbusy), .quot_o(dquot));

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {3'b0, res_q.added_slot, res_q.add_status, res_q.prev_index,
                         res_q.prev_found, res_q.next_index, res_q.next_found,
                         res_q.playhead_pixel, res_q.reached_end, res_q.is_playing,
                         res_q.playhead_now};

  always_comb begin
    len_d = len_q; width_d = width_q; speed_d = speed_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        ptm_pkg::REG_LENGTH: len_d = cfg_wdata_i;
        ptm_pkg::REG_WIDTH: width_d = (cfg_wdata_i[15:0] == 16'd0) ? 16'd1 : cfg_wdata_i[15:0];
        ptm_pkg::REG_SPEED: begin
          if (cfg_wdata_i[12:0] != 13'd0 && cfg_wdata_i[12:0] <= 13'(ptm_pkg::SpeedMax)) begin
            speed_d = cfg_wdata_i[12:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    // A step of 2^32 or more always reaches the end, so it is held at 2^32.
    step_w = (prod_q[44:40] != 5'd0) ? 33'h100000000 : {1'b0, prod_q[39:8]};
    if (step_w == 33'd0 && tv_q != 32'd0) step_w = 33'd1;
    sum_w = {1'b0, ph_q} + step_w;
    xcl = px_q[15] ? 16'd0 : ((px_q > width_q) ? width_q : px_q);
  end

  always_comb begin
    state_d = state_q; ph_d = ph_q; run_d = run_q; total_d = total_q;
    tv_d = tv_q; px_d = px_q; pos_d = pos_q;
    nf_d = nf_q; ni_d = ni_q; pf_d = pf_q; pi_d = pi_q;
    status_d = status_q; slot_d = slot_q; reached_d = reached_q;
    prod_d = prod_q; ovalid_d = ovalid_q; res_d = res_q;
    we = 1'b0; waddr = '0; wdata = tv_q; raddr = '0;
    dreq = '0;
    if (m_axis_tready && ovalid_q) ovalid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          tv_d = s_axis_tdata[34:3];
          px_d = s_axis_tdata[50:35];
          status_d = ptm_pkg::ST_NONE; slot_d = '0; reached_d = 1'b0;
          prod_d = 45'(s_axis_tdata[34:3] * speed_q + 45'd128);
          state_d = S_SRCH_RD;
          pos_d = '0;
          unique case (s_axis_tdata[2:0])
            ptm_pkg::OP_TICK: if (run_q) state_d = S_TICK;
            ptm_pkg::OP_PLAY: begin
              if (ph_q >= len_q) ph_d = '0;
              run_d = 1'b1;
            end
            ptm_pkg::OP_PAUSE: run_d = 1'b0;
            ptm_pkg::OP_TOGGLE: begin
              if (run_q) run_d = 1'b0;
              else begin
                if (ph_q >= len_q) ph_d = '0;
                run_d = 1'b1;
              end
            end
            ptm_pkg::OP_SEEK_TIME:
              ph_d = (s_axis_tdata[34:3] > len_q) ? len_q : s_axis_tdata[34:3];
            ptm_pkg::OP_SEEK_PIXEL: state_d = S_SPX;
            ptm_pkg::OP_ADD_MARKER: begin
              if (32'(total_q) >= MarkerSlots) status_d = ptm_pkg::ST_FULL;
              else if (s_axis_tdata[34:3] > len_q) status_d = ptm_pkg::ST_PAST_END;
              else begin
                pos_d = total_q;
                state_d = S_INS_RD;
              end
            end
            default: ;
          endcase
          nf_d = 1'b0; pf_d = 1'b0; ni_d = '0; pi_d = '0;
        end
      end
      S_TICK: begin
        if (sum_w >= {1'b0, len_q}) begin
          ph_d = len_q; run_d = 1'b0; reached_d = 1'b1;
        end else begin
          ph_d = sum_w[31:0];
        end
        state_d = S_SRCH_RD;
      end
      S_SPX: begin
        dreq.start = 1'b1;
        dreq.dividend = {16'd0, len_q} * {32'd0, xcl};
        dreq.divisor = {16'd0, width_q};
        state_d = S_SPXW;
      end
      S_SPXW: begin
        if (!dbusy) begin
          ph_d = dquot[31:0];
          state_d = S_SRCH_RD;
        end
      end
      S_INS_RD: begin
        if (pos_q == '0) begin
          we = 1'b1; waddr = '0; wdata = tv_q;
          total_d = total_q + 1'b1; status_d = ptm_pkg::ST_ADDED; slot_d = '0;
          pos_d = '0;
          state_d = S_SRCH_RD;
        end else begin
          raddr = AW'(pos_q - 1'b1);
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        we = 1'b1;
        waddr = AW'(pos_q);
        if (rdata > tv_q) begin
          wdata = rdata;
          pos_d = pos_q - 1'b1;
          state_d = S_INS_RD;
        end else begin
          wdata = tv_q;
          total_d = total_q + 1'b1; status_d = ptm_pkg::ST_ADDED; slot_d = AW'(pos_q);
          pos_d = '0;
          state_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (pos_q >= total_q) begin
          state_d = S_PIX;
        end else begin
          raddr = AW'(pos_q);
          state_d = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (rdata < ph_q) begin
          pf_d = 1'b1; pi_d = AW'(pos_q);
        end
        pos_d = pos_q + 1'b1;
        state_d = S_SRCH_RD;
        if (rdata > ph_q) begin
          nf_d = 1'b1; ni_d = AW'(pos_q);
          state_d = S_PIX;
        end
      end
      S_PIX: begin
        dreq.start = 1'b1;
        dreq.dividend = {16'd0, ph_q} * {32'd0, width_q};
        dreq.divisor = len_q;
        state_d = S_PIXW;
      end
      S_PIXW: begin
        if (!dbusy) state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          res_d.playhead_now = ph_q;
          res_d.is_playing = run_q;
          res_d.reached_end = reached_q;
          res_d.playhead_pixel = (len_q == '0) ? 16'd0 :
                                 ((dquot > 48'd65535) ? 16'hFFFF : dquot[15:0]);
          res_d.next_found = nf_q;
          res_d.next_index = 5'(ni_q);
          res_d.prev_found = pf_q;
          res_d.prev_index = 5'(pi_q);
          res_d.add_status = status_q;
          res_d.added_slot = 5'(slot_q);
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q <= '0; width_q <= 16'd1; speed_q <= 13'd256;
      ph_q <= '0; run_q <= 1'b0; total_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q <= len_d; width_q <= width_d; speed_q <= speed_d;
      ph_q <= ph_d; run_q <= run_d; total_q <= total_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tv_q <= tv_d; px_q <= px_d; pos_q <= pos_d;
    nf_q <= nf_d; ni_q <= ni_d; pf_q <= pf_d; pi_q <= pi_d;
    status_q <= status_d; slot_q <= slot_d; reached_q <= reached_d;
    prod_q <= prod_d; res_q <= res_d;
  end
endmodule

[rtl/ptm_checker.sv]
// Port-level checker for the playback timeline block and its bind.
module ptm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken during work");
  a_end_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33] |-> !m_axis_tdata[32])
    else $error("end reached but still playing");
endmodule

bind playback_timeline_with_markers ptm_checker u_ptm_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);

[dv/playback_timeline_with_markers_tb.sv]
// Self-checking testbench for the playback timeline block with its marker table.
`timescale 1ns / 1ps

module playback_timeline_with_markers_tb;
  localparam logic [1:0] RegUnused = 2'd3;
  localparam int unsigned Slots = 32;
  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned SettleCycles = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic [55:0] s_tdata = '0;
  logic m_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic [71:0] m_axis_tdata;

  // Timeline model.
  logic [31:0] tl_length = 32'd0;
  logic [15:0] tl_width = 16'd1;
  logic [12:0] tl_speed = 13'd256;
  logic [31:0] head_ms = 32'd0;
  logic running = 1'b0;
  logic [31:0] marker_ms [Slots];
  int unsigned marks_held = 0;

  ptm_pkg::result_t expected_results[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned hold_off = 0;

  playback_timeline_with_markers dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    ptm_pkg::result_t got;
    ptm_pkg::result_t want;
    if (m_axis_tvalid && m_tready) begin
      got = m_axis_tdata[$bits(ptm_pkg::result_t)-1:0];
      if (expected_results.size() == 0) begin
        $error("unexpected result %h", got);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.playhead_now !== want.playhead_now) begin
          $error("playhead_now exp %0d got %0d", want.playhead_now, got.playhead_now);
          fail_count++;
        end
        if (got.is_playing !== want.is_playing) begin
          $error("is_playing exp %0d got %0d", want.is_playing, got.is_playing);
          fail_count++;
        end
        if (got.reached_end !== want.reached_end) begin
          $error("reached_end exp %0d got %0d", want.reached_end, got.reached_end);
          fail_count++;
        end
        if (got.playhead_pixel !== want.playhead_pixel) begin
          $error("playhead_pixel exp %0d got %0d", want.playhead_pixel, got.playhead_pixel);
          fail_count++;
        end
        if (got.next_found !== want.next_found) begin
          $error("next_found exp %0d got %0d", want.next_found, got.next_found);
          fail_count++;
        end
        if (got.next_index !== want.next_index) begin
          $error("next_index exp %0d got %0d", want.next_index, got.next_index);
          fail_count++;
        end
        if (got.prev_found !== want.prev_found) begin
          $error("prev_found exp %0d got %0d", want.prev_found, got.prev_found);
          fail_count++;
        end
        if (got.prev_index !== want.prev_index) begin
          $error("prev_index exp %0d got %0d", want.prev_index, got.prev_index);
          fail_count++;
        end
        if (got.add_status !== want.add_status) begin
          $error("add_status exp %0d got %0d", want.add_status, got.add_status);
          fail_count++;
        end
        if (got.added_slot !== want.added_slot) begin
          $error("added_slot exp %0d got %0d", want.added_slot, got.added_slot);
          fail_count++;
        end
      end
    end
  end

  task automatic start_playback();
    if (head_ms >= tl_length) head_ms = 32'd0;
    running = 1'b1;
  endtask

  task automatic advance_timeline(input logic [2:0] op, input logic [31:0] tv,
                                  input logic [15:0] px);
    ptm_pkg::result_t r;
    logic [63:0] step;
    logic [63:0] prod;
    logic [15:0] x;
    int pos;
    r = '0;
    case (op)
      ptm_pkg::OP_TICK: begin
        if (running) begin
          step = ({32'd0, tv} * tl_speed + 64'd128) >> 8;
          if (step == 0 && tv != 0) step = 64'd1;
          if ({32'd0, head_ms} + step >= {32'd0, tl_length}) begin
            head_ms = tl_length;
            running = 1'b0;
            r.reached_end = 1'b1;
          end else begin
            head_ms = head_ms + step[31:0];
          end
        end
      end
      ptm_pkg::OP_PLAY: start_playback();
      ptm_pkg::OP_PAUSE: running = 1'b0;
      ptm_pkg::OP_TOGGLE: begin
        if (running) running = 1'b0;
        else start_playback();
      end
      ptm_pkg::OP_SEEK_TIME: head_ms = (tv > tl_length) ? tl_length : tv;
      ptm_pkg::OP_SEEK_PIXEL: begin
        if (px[15]) x = 16'd0;
        else x = (px > tl_width) ? tl_width : px;
        prod = {32'd0, tl_length} * x / tl_width;
        head_ms = prod[31:0];
      end
      ptm_pkg::OP_ADD_MARKER: begin
        if (marks_held >= Slots) begin
          r.add_status = ptm_pkg::ST_FULL;
        end else if (tv > tl_length) begin
          r.add_status = ptm_pkg::ST_PAST_END;
        end else begin
          pos = marks_held;
          while (pos > 0 && marker_ms[pos-1] > tv) begin
            marker_ms[pos] = marker_ms[pos-1];
            pos--;
          end
          marker_ms[pos] = tv;
          marks_held++;
          r.add_status = ptm_pkg::ST_ADDED;
          r.added_slot = pos[4:0];
        end
      end
      default: ;
    endcase
    for (int i = 0; i < marks_held; i++) begin
      if (marker_ms[i] > head_ms) begin
        r.next_found = 1'b1;
        r.next_index = i[4:0];
        break;
      end
    end
    for (int i = int'(marks_held) - 1; i >= 0; i--) begin
      if (marker_ms[i] < head_ms) begin
        r.prev_found = 1'b1;
        r.prev_index = i[4:0];
        break;
      end
    end
    r.playhead_now = head_ms;
    r.is_playing = running;
    if (tl_length != 0) begin
      prod = {32'd0, head_ms} * tl_width / tl_length;
      r.playhead_pixel = (prod > 64'd65535) ? 16'hFFFF : prod[15:0];
    end
    expected_results.push_back(r);
  endtask

  task automatic send_item(input logic [2:0] op, input logic [31:0] tv, input logic [15:0] px);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, px, tv, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    advance_timeline(op, tv, px);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      ptm_pkg::REG_LENGTH: tl_length = val;
      ptm_pkg::REG_WIDTH: tl_width = (val[15:0] == 0) ? 16'd1 : val[15:0];
      ptm_pkg::REG_SPEED: begin
        if (val[12:0] >= 1 && val[12:0] <= ptm_pkg::SpeedMax) tl_speed = val[12:0];
      end
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(tl_length, 0);
      2: return $urandom_range(300);
      default: return tl_length + $urandom_range(3) - 1;
    endcase
  endfunction

  function automatic logic [2:0] pick_op();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 35) return ptm_pkg::OP_TICK;
    if (w < 45) return ptm_pkg::OP_PLAY;
    if (w < 50) return ptm_pkg::OP_PAUSE;
    if (w < 58) return ptm_pkg::OP_TOGGLE;
    if (w < 70) return ptm_pkg::OP_SEEK_TIME;
    if (w < 82) return ptm_pkg::OP_SEEK_PIXEL;
    if (w < 96) return ptm_pkg::OP_ADD_MARKER;
    return 3'd7;
  endfunction

  task automatic test_directed();
    write_reg(ptm_pkg::REG_LENGTH, 32'd1000);
    write_reg(ptm_pkg::REG_WIDTH, 32'd100);
    write_reg(ptm_pkg::REG_SPEED, 32'd256);
    send_item(ptm_pkg::OP_TICK, 32'd50, 16'd0);
    send_item(ptm_pkg::OP_ADD_MARKER, 32'd300, 16'd0);
    send_item(ptm_pkg::OP_ADD_MARKER, 32'd300, 16'd0);
    send_item(ptm_pkg::OP_ADD_MARKER, 32'd0, 16'd0);
    send_item(ptm_pkg::OP_ADD_MARKER, 32'd1000, 16'd0);
    send_item(ptm_pkg::OP_ADD_MARKER, 32'd1001, 16'd0);
    send_item(ptm_pkg::OP_PLAY, 32'd0, 16'd0);
    send_item(ptm_pkg::OP_TICK, 32'd0, 16'd0);
    send_item(ptm_pkg::OP_TICK, 32'd1, 16'd0);
    send_item(ptm_pkg::OP_TICK, 32'd299, 16'd0);
    send_item(ptm_pkg::OP_TICK, 32'hFFFF_FFFF, 16'd0);
    send_item(ptm_pkg::OP_TICK, 32'd0, 16'd0);
    send_item(ptm_pkg::OP_PLAY, 32'd0, 16'd0);
    send_item(ptm_pkg::OP_PAUSE, 32'd0, 16'd0);
    send_item(ptm_pkg::OP_TOGGLE, 32'd0, 16'd0);
    send_item(ptm_pkg::OP_TOGGLE, 32'd0, 16'd0);
    send_item(ptm_pkg::OP_SEEK_TIME, 32'd300, 16'd0);
    send_item(ptm_pkg::OP_SEEK_TIME, 32'hFFFF_FFFF, 16'd0);
    send_item(ptm_pkg::OP_TOGGLE, 32'd0, 16'd0);
    send_item(ptm_pkg::OP_SEEK_PIXEL, 32'd0, 16'd50);
    send_item(ptm_pkg::OP_SEEK_PIXEL, 32'd0, 16'h8000);
    send_item(ptm_pkg::OP_SEEK_PIXEL, 32'd0, 16'h7FFF);
    send_item(3'd7, 32'hFFFF_FFFF, 16'hFFFF);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(ptm_pkg::REG_SPEED, 32'd0);
    write_reg(ptm_pkg::REG_SPEED, 32'd5000);
    write_reg(ptm_pkg::REG_WIDTH, 32'd0);
    write_reg(RegUnused, 32'hFFFF_FFFF);
    send_item(ptm_pkg::OP_SEEK_PIXEL, 32'd0, 16'd1);
    send_item(ptm_pkg::OP_PLAY, 32'd0, 16'd0);
    send_item(ptm_pkg::OP_TICK, 32'd10, 16'd0);
    drain();
    write_reg(ptm_pkg::REG_SPEED, 32'd1);
    write_reg(ptm_pkg::REG_LENGTH, 32'hFFFF_FFFF);
    write_reg(ptm_pkg::REG_WIDTH, 32'd65535);
    send_item(ptm_pkg::OP_SEEK_TIME, 32'hF000_0000, 16'd0);
    send_item(ptm_pkg::OP_PLAY, 32'd0, 16'd0);
    send_item(ptm_pkg::OP_TICK, 32'd127, 16'd0);
    send_item(ptm_pkg::OP_TICK, 32'hFFFF_FFFF, 16'd0);
    drain();
    write_reg(ptm_pkg::REG_SPEED, ptm_pkg::SpeedMax);
    write_reg(ptm_pkg::REG_LENGTH, 32'd100);
    send_item(ptm_pkg::OP_TICK, 32'd0, 16'd0);
    send_item(ptm_pkg::OP_SEEK_PIXEL, 32'd0, 16'd65535);
    send_item(ptm_pkg::OP_PLAY, 32'd0, 16'd0);
    send_item(ptm_pkg::OP_TICK, 32'd3, 16'd0);
    send_item(ptm_pkg::OP_TICK, 32'hFFFF_FFFF, 16'd0);
    drain();
    write_reg(ptm_pkg::REG_LENGTH, 32'd0);
    send_item(ptm_pkg::OP_PLAY, 32'd0, 16'd0);
    send_item(ptm_pkg::OP_TICK, 32'd0, 16'd0);
    send_item(ptm_pkg::OP_SEEK_PIXEL, 32'd0, 16'd7);
    drain();
  endtask

  task automatic test_random_phase(input int unsigned src_pct, input int unsigned snk_pct,
                                   input int unsigned count);
    logic [31:0] len_sel [4];
    len_sel = '{32'd1000, 32'd60000, $urandom, 32'd7};
    write_reg(ptm_pkg::REG_LENGTH, len_sel[$urandom_range(3)]);
    write_reg(ptm_pkg::REG_WIDTH, $urandom_range(65535, 1));
    write_reg(ptm_pkg::REG_SPEED, $urandom_range(ptm_pkg::SpeedMax, 1));
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (count) send_item(pick_op(), pick_time(), 16'($urandom));
    drain();
    src_idle_pct = 0;
    snk_idle_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_off = 3000;
    repeat (20) send_item(pick_op(), pick_time(), 16'($urandom));
    drain();
  endtask

  task automatic test_full_table();
    write_reg(ptm_pkg::REG_LENGTH, 32'hFFFF_FFFF);
    while (marks_held < Slots) send_item(ptm_pkg::OP_ADD_MARKER, $urandom, 16'($urandom));
    send_item(ptm_pkg::OP_ADD_MARKER, 32'd5, 16'd0);
    send_item(ptm_pkg::OP_SEEK_TIME, $urandom, 16'd0);
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random_phase(0, 0, 150);
    test_random_phase(70, 0, 130);
    test_backpressure();
    test_random_phase(0, 70, 130);
    test_random_phase(32, 32, 150);
    test_full_table();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
